// ----- hdl/slcan_pkg.sv -----
// ----------------------------------------------------------------------------
// slcan_pkg
// Shared types, constants and helper functions of the ASCII CAN command parser.
// ----------------------------------------------------------------------------
package slcan_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_0   = 8'h30;
  localparam logic [7:0] CHR_1   = 8'h31;
  localparam logic [7:0] CHR_9   = 8'h39;
  localparam logic [7:0] CHR_UA  = 8'h41;
  localparam logic [7:0] CHR_UF  = 8'h46;
  localparam logic [7:0] CHR_LA  = 8'h61;
  localparam logic [7:0] CHR_LF  = 8'h66;
  localparam logic [7:0] CHR_N   = 8'h4E;
  localparam logic [7:0] CHR_V   = 8'h56;
  localparam logic [7:0] CHR_T   = 8'h54;
  localparam logic [7:0] CHR_R   = 8'h52;
  localparam logic [7:0] CHR_LT  = 8'h74;
  localparam logic [7:0] CHR_LR  = 8'h72;

  localparam logic [3:0] STD_ID_DIGITS = 4'd3;
  localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
  localparam logic [3:0] DLC_MAX       = 4'd8;
  localparam logic [2:0] TEXT_LAST     = 3'd5;
  localparam int         ID_W          = 29;
  localparam int         STD_ID_W      = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FRAME,
    ST_REPLY_CR,
    ST_TEXT
  } slcan_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_nib_t;

  function automatic hex_nib_t hex_decode(input logic [7:0] ch);
    hex_nib_t   res;
    logic [7:0] diff;
    res  = '0;
    diff = '0;
    if (ch >= CHR_0 && ch <= CHR_9) begin
      diff      = ch - CHR_0;
      res.valid = 1'b1;
      res.value = diff[3:0];
    end else if (ch >= CHR_UA && ch <= CHR_UF) begin
      diff      = ch - CHR_UA + 8'd10;
      res.valid = 1'b1;
      res.value = diff[3:0];
    end else if (ch >= CHR_LA && ch <= CHR_LF) begin
      diff      = ch - CHR_LA + 8'd10;
      res.valid = 1'b1;
      res.value = diff[3:0];
    end
    return res;
  endfunction

  // Fixed six-character replies: version ("V0101\r") or serial ("N0000\r").
  function automatic logic [7:0] text_char(input logic serial, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = serial ? CHR_N : CHR_V;
      3'd1:    ch = CHR_0;
      3'd2:    ch = serial ? CHR_0 : CHR_1;
      3'd3:    ch = CHR_0;
      3'd4:    ch = serial ? CHR_0 : CHR_1;
      default: ch = CHR_CR;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/slcan_ram.sv -----
// ----------------------------------------------------------------------------
// slcan_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module slcan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/slcan_ascii_command_parser_unit.sv -----
// ----------------------------------------------------------------------------
// slcan_ascii_command_parser_unit
// Line buffer and parser for ASCII serial-line CAN commands.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Direction | Per request
//  --------+-----------------------------------------+-----------+---------------------
//  in      | in_valid/in_ready, in_rx_char           | to block  | one received char
//  out     | out_valid/out_ready, out_kind, out_*    | from block| frame or reply byte
//
// A character other than carriage return is written to the line RAM at
// the current length (or the line is dropped when full).
// A carriage return walks the stored line through the RAM read port, one
// character a cycle from the registered read data; each result is then
// held on the output until it is taken.
// Reset (rst_n low, synchronous) empties the line and idles the walker; the
// RAM content is not cleared. Output stalls hold the walker in place, and
// no new character is taken until every result of a line end is delivered.
//
module slcan_ascii_command_parser_unit #(
  parameter int LINE_DEPTH = slcan_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [28:0] out_can_id,
  output logic        out_is_extended,
  output logic        out_is_remote,
  output logic [3:0]  out_data_count,
  output logic [63:0] out_payload,
  output logic [7:0]  out_reply_char,
  output logic        out_last
);

  import slcan_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  // Control state
  slcan_state_t  state_r, state_nxt;
  logic [AW-1:0] len_r, len_nxt;

  // Walker registers
  logic [4:0]      pos_r, pos_nxt;
  logic            ext_r, ext_nxt;
  logic            rem_r, rem_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [3:0]      dlc_r, dlc_nxt;
  logic [63:0]     data_r, data_nxt;
  logic            txt_sel_r, txt_sel_nxt;
  logic [2:0]      txt_idx_r, txt_idx_nxt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  // Walk decode
  hex_nib_t   nib;
  logic [3:0] id_len;
  logic [3:0] dlc_clamp;
  logic [4:0] need;
  logic [4:0] nib_k;
  logic [4:0] nib_last;
  logic       cmd_ext, cmd_rem;

  slcan_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_rx_char),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    ext_r     <= ext_nxt;
    rem_r     <= rem_nxt;
    id_r      <= id_nxt;
    dlc_r     <= dlc_nxt;
    data_r    <= data_nxt;
    txt_sel_r <= txt_sel_nxt;
    txt_idx_r <= txt_idx_nxt;
  end

  assign nib       = hex_decode(ram_rdata);
  assign id_len    = ext_r ? EXT_ID_DIGITS : STD_ID_DIGITS;
  assign dlc_clamp = (nib.value > DLC_MAX) ? DLC_MAX : nib.value;
  assign nib_k     = pos_r - {1'b0, id_len} - 5'd2;
  assign nib_last  = {dlc_r, 1'b0} - 5'd1;
  assign cmd_ext   = (ram_rdata == CHR_T) || (ram_rdata == CHR_R);
  assign cmd_rem   = (ram_rdata == CHR_LR) || (ram_rdata == CHR_R);
  // Characters needed once the DLC is known
  assign need      = {1'b0, id_len} + 5'd2 + (rem_r ? 5'd0 : {dlc_clamp, 1'b0});

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    ext_nxt     = ext_r;
    rem_nxt     = rem_r;
    id_nxt      = id_r;
    dlc_nxt     = dlc_r;
    data_nxt    = data_r;
    txt_sel_nxt = txt_sel_r;
    txt_idx_nxt = txt_idx_r;
    ram_we      = 1'b0;
    ram_addr    = AW'(pos_r) + AW'(1);
    in_ready    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_rx_char == CHR_CR) begin
          // Start the walk: read the command character.
          ram_addr = '0;
          if (in_valid && len_r != '0) begin
            pos_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end else begin
          ram_addr = len_r;
          if (in_valid) begin
            if (len_r != AW'(LINE_DEPTH - 1)) begin
              ram_we  = 1'b1;
              len_nxt = len_r + AW'(1);
            end else begin
              // Full line: drop the character and the line.
              len_nxt = '0;
            end
          end
        end
      end

      ST_WALK: begin
        pos_nxt = pos_r + 5'd1;
        if (pos_r == '0) begin
          id_nxt   = '0;
          data_nxt = '0;
          dlc_nxt  = '0;
          ext_nxt  = cmd_ext;
          rem_nxt  = cmd_rem;
          if (ram_rdata == CHR_V || ram_rdata == CHR_N) begin
            txt_sel_nxt = (ram_rdata == CHR_N);
            txt_idx_nxt = '0;
            state_nxt   = ST_TEXT;
          end else if (ram_rdata == CHR_LT || ram_rdata == CHR_T ||
                       ram_rdata == CHR_LR || ram_rdata == CHR_R) begin
            // Short line: not even id and DLC present.
            if (len_r < AW'({1'b0, cmd_ext ? EXT_ID_DIGITS : STD_ID_DIGITS} + 5'd2)) begin
              state_nxt = ST_REPLY_CR;
            end
          end else begin
            state_nxt = ST_REPLY_CR;
          end
        end else if (pos_r <= {1'b0, id_len}) begin
          if (!nib.valid) begin
            state_nxt = ST_REPLY_CR;
          end else begin
            id_nxt = {id_r[ID_W-5:0], nib.value};
          end
        end else if (pos_r == {1'b0, id_len} + 5'd1) begin
          dlc_nxt = dlc_clamp;
          if (!nib.valid || len_r < AW'(need)) begin
            state_nxt = ST_REPLY_CR;
          end else if (rem_r || dlc_clamp == '0) begin
            state_nxt = ST_FRAME;
          end
        end else begin
          // Data nibbles: high nibble of each byte first.
          if (!nib.valid) begin
            state_nxt = ST_REPLY_CR;
          end else begin
            data_nxt[{nib_k[3:1], ~nib_k[0], 2'b00} +: 4] = nib.value;
            if (nib_k == nib_last) begin
              state_nxt = ST_FRAME;
            end
          end
        end
      end

      ST_FRAME: begin
        if (out_ready) begin
          state_nxt = ST_REPLY_CR;
        end
      end

      ST_REPLY_CR: begin
        if (out_ready) begin
          len_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_TEXT: begin
        if (out_ready) begin
          txt_idx_nxt = txt_idx_r + 3'd1;
          if (txt_idx_r == TEXT_LAST) begin
            len_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields come straight from the walker registers.
  always_comb begin
    out_valid       = 1'b0;
    out_kind        = 1'b1;
    out_can_id      = '0;
    out_is_extended = 1'b0;
    out_is_remote   = 1'b0;
    out_data_count  = '0;
    out_payload     = '0;
    out_reply_char  = '0;
    out_last        = 1'b0;
    case (state_r)
      ST_FRAME: begin
        out_valid       = 1'b1;
        out_kind        = 1'b0;
        out_can_id      = ext_r ? id_r : {{(ID_W - STD_ID_W){1'b0}}, id_r[STD_ID_W-1:0]};
        out_is_extended = ext_r;
        out_is_remote   = rem_r;
        out_data_count  = dlc_r;
        out_payload     = data_r;
      end
      ST_REPLY_CR: begin
        out_valid      = 1'b1;
        out_reply_char = CHR_CR;
        out_last       = 1'b1;
      end
      ST_TEXT: begin
        out_valid      = 1'b1;
        out_reply_char = text_char(txt_sel_r, txt_idx_r);
        out_last       = (txt_idx_r == TEXT_LAST);
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

endmodule
